/* rtl/pps_pkg.sv */
// shared types and constants for the preemptive priority scheduler
// no dependencies

package pps_pkg;

   localparam int ARR_W   = 20;
   localparam int BURST_W = 16;
   localparam int PRIO_W  = 8;
   localparam int EV_W    = 3;
   localparam int ID_W    = 5;
   localparam int OUT_T_W = 20;
   localparam int TOTAL_W = 24;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   typedef enum logic [EV_W-1:0] {
      EV_LOADED = 3'd0,
      EV_IDLE   = 3'd1,
      EV_RAN    = 3'd2,
      EV_DONE   = 3'd3,
      EV_FULL   = 3'd4
   } event_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT,
      ST_METRIC,
      ST_TOTAL
   } state_type;

   typedef struct packed {
      logic load;
      logic scan_init;
      logic scan_read;
      logic commit;
      logic metric;
      logic total;
   } cmd_type;

   typedef struct packed {
      logic table_empty;
      logic scan_last;
   } sts_type;

endpackage

/* rtl/pps_ctrl.sv */
// sequencer for the scheduler: load transfers, slot scan and commit steps
// depends on pps_pkg

module pps_ctrl import pps_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    req_action,
   input  sts_type sts,
   output logic    busy,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               if (req_action == ACT_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.scan_init = 1'b1;
                  state_in = sts.table_empty ? ST_COMMIT : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_read = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         // last read word is judged here
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in = ST_METRIC;
         end
         ST_METRIC: begin
            cmd.metric = 1'b1;
            state_in = ST_TOTAL;
         end
         ST_TOTAL: begin
            cmd.total = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/pps_datapath.sv */
// task table memory, scan compare, time and completion statistics
// depends on pps_pkg

module pps_datapath import pps_pkg::*; #(
   parameter int MAX_TASKS = 16,
   parameter int TIME_BITS = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output sts_type              sts,
   input  logic [ARR_W-1:0]     req_arrival_time,
   input  logic [BURST_W-1:0]   req_burst_length,
   input  logic [PRIO_W-1:0]    req_task_priority,
   output logic                 rsp_valid,
   output logic [EV_W-1:0]      rsp_event_res,
   output logic [ID_W-1:0]      rsp_task_id,
   output logic [OUT_T_W-1:0]   rsp_tick_time,
   output logic [OUT_T_W-1:0]   rsp_turnaround,
   output logic [OUT_T_W-1:0]   rsp_wait_time,
   output logic [OUT_T_W-1:0]   rsp_response,
   output logic [ID_W-1:0]      rsp_done_count,
   output logic [TOTAL_W-1:0]   rsp_sum_turnaround,
   output logic [TOTAL_W-1:0]   rsp_sum_wait,
   output logic [TOTAL_W-1:0]   rsp_sum_response
);

   localparam int IW   = $clog2(MAX_TASKS);
   localparam int CNTW = $clog2(MAX_TASKS + 1);
   localparam int CW   = (TIME_BITS > ARR_W) ? TIME_BITS : ARR_W;
   localparam int SW   = (CW > TOTAL_W) ? CW : TOTAL_W;
   localparam int XW   = (CNTW > ID_W) ? CNTW : ID_W;

   typedef struct packed {
      logic                 started;
      logic [TIME_BITS-1:0] first_run;
      logic [PRIO_W-1:0]    prio;
      logic [BURST_W-1:0]   remaining;
      logic [BURST_W-1:0]   burst;
      logic [ARR_W-1:0]     arrival;
   } row_type;

   row_type mem [MAX_TASKS];

   logic [CNTW-1:0]      loaded_ff, done_ff;
   logic [TIME_BITS-1:0] now_ff, start_time_ff;
   logic [TOTAL_W-1:0]   sum_t_ff, sum_w_ff, sum_r_ff;
   logic [IW-1:0]        scan_addr_ff, rd_slot_ff, best_slot_ff;
   row_type              rd_row_ff, best_ff;
   logic                 rd_valid_ff, found_ff, finish_ff;
   logic [CW-1:0]        tat_ff, resp_ff, wt_ff;

   logic                 rsp_valid_ff;
   event_type            rsp_event_ff;
   logic [ID_W-1:0]      rsp_id_ff;
   logic [OUT_T_W-1:0]   rsp_tick_ff, rsp_tat_ff, rsp_wt_ff, rsp_resp_ff;

   logic                 full, take, we;
   logic [IW-1:0]        wa;
   row_type              wd;
   logic [TIME_BITS-1:0] now_inc, first_new;
   logic [BURST_W-1:0]   rem_dec;
   logic [CW-1:0]        tat_c, resp_c, wt_c, now_ext;
   logic [XW-1:0]        load_id_x, run_id_x, done_x;

   function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                   input logic [CW-1:0] b);
      logic [SW:0] s;
      s = (SW+1)'(a) + (SW+1)'(b);
      return (s > (SW+1)'(TOTAL_MAX)) ? TOTAL_MAX : s[TOTAL_W-1:0];
   endfunction

   assign full = (loaded_ff == CNTW'(MAX_TASKS));
   assign sts.table_empty = (loaded_ff == '0);
   assign sts.scan_last   = (CNTW'(scan_addr_ff) == loaded_ff - CNTW'(1));

   // scan compare on the registered read word
   assign take = rd_valid_ff
               && (CW'(rd_row_ff.arrival) <= CW'(now_ff))
               && (rd_row_ff.remaining != '0)
               && (!found_ff || (rd_row_ff.prio > best_ff.prio));

   assign now_inc   = (now_ff == '1) ? now_ff : now_ff + TIME_BITS'(1);
   assign rem_dec   = best_ff.remaining - BURST_W'(1);
   assign first_new = best_ff.started ? best_ff.first_run : now_ff;
   assign tat_c     = CW'(now_inc) - CW'(best_ff.arrival);
   assign resp_c    = CW'(first_new) - CW'(best_ff.arrival);
   assign wt_c      = (tat_ff >= CW'(best_ff.burst)) ? tat_ff - CW'(best_ff.burst) : '0;
   assign now_ext   = CW'(now_ff);
   assign load_id_x = XW'(loaded_ff) + XW'(1);
   assign run_id_x  = XW'(best_slot_ff) + XW'(1);
   assign done_x    = XW'(done_ff);

   always_comb begin
      we = 1'b0;
      wa = best_slot_ff;
      wd = best_ff;
      if (cmd.load && !full) begin
         we = 1'b1;
         wa = loaded_ff[IW-1:0];
         wd.arrival   = req_arrival_time;
         wd.burst     = req_burst_length;
         wd.remaining = req_burst_length;
         wd.prio      = req_task_priority;
         wd.first_run = '0;
         wd.started   = 1'b0;
      end else if (cmd.commit && found_ff) begin
         we = 1'b1;
         wd.remaining = rem_dec;
         wd.first_run = first_new;
         wd.started   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_row_ff  <= mem[scan_addr_ff];
      rd_slot_ff <= scan_addr_ff;
   end

   // scan bookkeeping and the commit stages
   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         scan_addr_ff <= '0;
      end else if (cmd.scan_read) begin
         scan_addr_ff <= scan_addr_ff + IW'(1);
      end
      if (take) begin
         best_ff      <= rd_row_ff;
         best_slot_ff <= rd_slot_ff;
      end
      if (cmd.commit) begin
         start_time_ff <= now_ff;
         finish_ff     <= found_ff && (rem_dec == '0);
         tat_ff        <= tat_c;
         resp_ff       <= resp_c;
      end
      if (cmd.metric) begin
         wt_ff <= wt_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff    <= '0;
         done_ff      <= '0;
         now_ff       <= '0;
         sum_t_ff     <= '0;
         sum_w_ff     <= '0;
         sum_r_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff  <= cmd.scan_read;
         rsp_valid_ff <= cmd.load || cmd.total;
         if (cmd.load && !full) begin
            loaded_ff <= loaded_ff + CNTW'(1);
         end
         if (cmd.scan_init) begin
            found_ff <= 1'b0;
         end else if (take) begin
            found_ff <= 1'b1;
         end
         if (cmd.commit) begin
            now_ff <= now_inc;
         end
         if (cmd.metric && finish_ff) begin
            done_ff  <= done_ff + CNTW'(1);
            sum_t_ff <= sat_add(sum_t_ff, tat_ff);
            sum_r_ff <= sat_add(sum_r_ff, resp_ff);
         end
         if (cmd.total && finish_ff) begin
            sum_w_ff <= sat_add(sum_w_ff, wt_ff);
         end
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_event_ff <= full ? EV_FULL : EV_LOADED;
         rsp_id_ff    <= full ? '0 : load_id_x[ID_W-1:0];
         rsp_tick_ff  <= now_ext[OUT_T_W-1:0];
         rsp_tat_ff   <= '0;
         rsp_wt_ff    <= '0;
         rsp_resp_ff  <= '0;
      end else if (cmd.total) begin
         if (!found_ff) begin
            rsp_event_ff <= EV_IDLE;
         end else if (finish_ff) begin
            rsp_event_ff <= EV_DONE;
         end else begin
            rsp_event_ff <= EV_RAN;
         end
         rsp_id_ff   <= found_ff ? run_id_x[ID_W-1:0] : '0;
         rsp_tick_ff <= OUT_T_W'(start_time_ff);
         rsp_tat_ff  <= finish_ff ? tat_ff[OUT_T_W-1:0] : '0;
         rsp_wt_ff   <= finish_ff ? wt_ff[OUT_T_W-1:0] : '0;
         rsp_resp_ff <= finish_ff ? resp_ff[OUT_T_W-1:0] : '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_res      = rsp_event_ff;
   assign rsp_task_id        = rsp_id_ff;
   assign rsp_tick_time      = rsp_tick_ff;
   assign rsp_turnaround     = rsp_tat_ff;
   assign rsp_wait_time      = rsp_wt_ff;
   assign rsp_response       = rsp_resp_ff;
   assign rsp_done_count     = done_x[ID_W-1:0];
   assign rsp_sum_turnaround = sum_t_ff;
   assign rsp_sum_wait       = sum_w_ff;
   assign rsp_sum_response   = sum_r_ff;

endmodule

/* rtl/preemptive_priority_scheduler_top.sv */
// top level of the preemptive priority scheduler
// depends on pps_pkg, pps_ctrl and pps_datapath
//
// usage:
//   a request transfer happens on a rising edge with start high and busy low.
//   req_action low loads one task (arrival, burst, priority) into the next
//   free slot; req_action high advances one time tick.
//   each request gives exactly one result, shown for a single cycle with
//   rsp_valid high; the receiver has no way to stall it.
// load and tick sequencing:
//   load: result in the cycle after the transfer, busy stays low, so a load
//   can follow every cycle.
//   tick: the slot table is scanned one slot per cycle through the table
//   memory's read port, then three commit steps update the chosen task,
//   time and the running totals. with tasks loaded busy stays high
//   through the scan, a drain step and the commit steps; the result
//   is registered from the last step; an empty table skips scan and drain.
// reset:
//   synchronous, active high; clears task count, time, completion count and
//   totals. the slot table itself is not cleared.

module preemptive_priority_scheduler_top import pps_pkg::*; #(
   parameter int MAX_TASKS = 16,
   parameter int TIME_BITS = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_action,
   input  logic [ARR_W-1:0]     req_arrival_time,
   input  logic [BURST_W-1:0]   req_burst_length,
   input  logic [PRIO_W-1:0]    req_task_priority,
   output logic                 rsp_valid,
   output logic [EV_W-1:0]      rsp_event_res,
   output logic [ID_W-1:0]      rsp_task_id,
   output logic [OUT_T_W-1:0]   rsp_tick_time,
   output logic [OUT_T_W-1:0]   rsp_turnaround,
   output logic [OUT_T_W-1:0]   rsp_wait_time,
   output logic [OUT_T_W-1:0]   rsp_response,
   output logic [ID_W-1:0]      rsp_done_count,
   output logic [TOTAL_W-1:0]   rsp_sum_turnaround,
   output logic [TOTAL_W-1:0]   rsp_sum_wait,
   output logic [TOTAL_W-1:0]   rsp_sum_response
);

   cmd_type cmd;
   sts_type sts;

   pps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .sts        (sts),
      .busy       (busy),
      .cmd        (cmd)
   );

   pps_datapath #(
      .MAX_TASKS (MAX_TASKS),
      .TIME_BITS (TIME_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_arrival_time   (req_arrival_time),
      .req_burst_length   (req_burst_length),
      .req_task_priority  (req_task_priority),
      .rsp_valid          (rsp_valid),
      .rsp_event_res      (rsp_event_res),
      .rsp_task_id        (rsp_task_id),
      .rsp_tick_time      (rsp_tick_time),
      .rsp_turnaround     (rsp_turnaround),
      .rsp_wait_time      (rsp_wait_time),
      .rsp_response       (rsp_response),
      .rsp_done_count     (rsp_done_count),
      .rsp_sum_turnaround (rsp_sum_turnaround),
      .rsp_sum_wait       (rsp_sum_wait),
      .rsp_sum_response   (rsp_sum_response)
   );

endmodule
